// File: hdl/rlr_pkg.sv
// region list reserve: shared constants, types and codes
// used by rlr_ctrl, rlr_dp and region_list_reserve; no dependencies
`default_nettype none

package rlr_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int ADDR_BITS   = 48;

  localparam int IDX_W     = $clog2(MAX_REGIONS);
  localparam int CNT_W     = $clog2(MAX_REGIONS + 1);
  localparam int STATUS_W  = 2;
  localparam int MEM_DEPTH = 2 * MAX_REGIONS;
  localparam int MEM_AW    = IDX_W + 1;

  // stream word widths, packed from bit 0 up and filled to whole bytes
  localparam int IN_DATA_W  = ((2 * ADDR_BITS + 7) / 8) * 8;
  localparam int OUT_USED_W = 2 * ADDR_BITS + CNT_W + STATUS_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    addr_t low;
    addr_t high;
  } region_t;

  // command codes
  localparam logic CMD_INIT    = 1'b0;
  localparam logic CMD_RESERVE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LIST_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK_RD,
    S_WALK_PROC,
    S_WALK_SPLIT,
    S_COMMIT,
    S_EMIT_START,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_EMPTY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic                load_in;
    logic                init_wr;
    logic                walk_clr;
    logic                proc;
    logic                split_wr;
    logic                idx_clr;
    logic                idx_inc;
    logic                commit;
    logic                set_status;
    logic [STATUS_W-1:0] status_val;
    logic                emit_ld;
    logic                emit_empty;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_range;
    logic is_init;
    logic count_zero;
    logic idx_last;
    logic split_hit;
    logic list_full;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/rlr_ctrl.sv
// region list reserve: sequencing state machine
// depends on rlr_pkg; drives rlr_dp through ctrl_cmd_t
`default_nettype none

module rlr_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire rlr_pkg::dp_stat_t  stat,
  output rlr_pkg::ctrl_cmd_t      cmd
);

  rlr_pkg::state_t state_r;
  rlr_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.status_val = rlr_pkg::ST_OK;
    in_tready      = 1'b0;
    unique case (state_r)
      rlr_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = rlr_pkg::S_DECIDE;
        end
      end
      rlr_pkg::S_DECIDE: begin
        cmd.set_status = 1'b1;
        if (stat.bad_range) begin
          cmd.status_val = rlr_pkg::ST_BAD_RANGE;
          state_nxt      = rlr_pkg::S_EMIT_START;
        end else if (stat.is_init) begin
          cmd.init_wr = 1'b1;
          state_nxt   = rlr_pkg::S_EMIT_START;
        end else begin
          cmd.walk_clr = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = stat.count_zero ? rlr_pkg::S_COMMIT : rlr_pkg::S_WALK_RD;
        end
      end
      rlr_pkg::S_WALK_RD: begin
        state_nxt = rlr_pkg::S_WALK_PROC;
      end
      rlr_pkg::S_WALK_PROC: begin
        if (stat.split_hit && stat.list_full) begin
          // abandon the new copy, old bank stays live
          cmd.set_status = 1'b1;
          cmd.status_val = rlr_pkg::ST_LIST_FULL;
          state_nxt      = rlr_pkg::S_EMIT_START;
        end else if (stat.split_hit) begin
          cmd.proc  = 1'b1;
          state_nxt = rlr_pkg::S_WALK_SPLIT;
        end else if (stat.idx_last) begin
          cmd.proc  = 1'b1;
          state_nxt = rlr_pkg::S_COMMIT;
        end else begin
          cmd.proc    = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt   = rlr_pkg::S_WALK_RD;
        end
      end
      rlr_pkg::S_WALK_SPLIT: begin
        cmd.split_wr = 1'b1;
        if (stat.idx_last) begin
          state_nxt = rlr_pkg::S_COMMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = rlr_pkg::S_WALK_RD;
        end
      end
      rlr_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = rlr_pkg::S_EMIT_START;
      end
      rlr_pkg::S_EMIT_START: begin
        cmd.idx_clr = 1'b1;
        state_nxt   = stat.count_zero ? rlr_pkg::S_EMIT_EMPTY : rlr_pkg::S_EMIT_RD;
      end
      rlr_pkg::S_EMIT_RD: begin
        if (stat.out_free) begin
          state_nxt = rlr_pkg::S_EMIT_LD;
        end
      end
      rlr_pkg::S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        if (stat.idx_last) begin
          state_nxt = rlr_pkg::S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = rlr_pkg::S_EMIT_RD;
        end
      end
      rlr_pkg::S_EMIT_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = rlr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rlr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/rlr_dp.sv
// region list reserve: two-bank region store, walk compare logic, output register
// depends on rlr_pkg; commanded by rlr_ctrl
`default_nettype none

module rlr_dp (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire  [rlr_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire                                in_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [rlr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast,
  input  wire  rlr_pkg::ctrl_cmd_t           cmd,
  output rlr_pkg::dp_stat_t                  stat
);

  // latched command
  logic                         cmd_r;
  rlr_pkg::addr_t               lo_r;
  rlr_pkg::addr_t               hi_r;

  // list bookkeeping
  logic                         bank_r;
  logic [rlr_pkg::CNT_W-1:0]    count_r;
  logic [rlr_pkg::IDX_W-1:0]    idx_r;
  logic [rlr_pkg::CNT_W-1:0]    n_r;
  logic                         copy_r;
  logic [rlr_pkg::STATUS_W-1:0] status_r;

  // store: bank_r selects the live half, the walk writes the other half
  rlr_pkg::region_t             mem_r [rlr_pkg::MEM_DEPTH];
  rlr_pkg::region_t             rd_q_r;

  // output register
  logic                         out_tvalid_r;
  rlr_pkg::addr_t               out_low_r;
  rlr_pkg::addr_t               out_high_r;
  logic                         out_entry_valid_r;
  logic [rlr_pkg::CNT_W-1:0]    out_count_r;
  logic [rlr_pkg::STATUS_W-1:0] out_status_r;
  logic                         out_last_r;

  logic                         rl_lt_lo;
  logic                         rh_lt_lo;
  logic                         rh_lt_hi;
  logic                         rl_lt_hi;
  logic                         keep;
  rlr_pkg::region_t             piece;
  logic                         wr_en;
  logic [rlr_pkg::MEM_AW-1:0]   wr_addr;
  rlr_pkg::region_t             wr_data;
  logic [rlr_pkg::MEM_AW-1:0]   rd_addr;

  // compare the entry under the walk against the reserved range
  assign rl_lt_lo = rd_q_r.low  < lo_r;
  assign rh_lt_lo = rd_q_r.high < lo_r;
  assign rh_lt_hi = rd_q_r.high < hi_r;
  assign rl_lt_hi = rd_q_r.low  < hi_r;

  always_comb begin
    keep  = 1'b1;
    piece = rd_q_r;
    if (!copy_r) begin
      if (rl_lt_lo) begin
        // clamp at the bottom of the range, also the lower half of a split
        if (!rh_lt_lo) begin
          piece.high = lo_r;
        end
      end else if (rl_lt_hi) begin
        if (rh_lt_hi) begin
          keep = 1'b0;
        end else begin
          piece.low = hi_r;
        end
      end
    end
  end

  assign stat.split_hit  = !copy_r && rl_lt_lo && !rh_lt_lo && !rh_lt_hi;
  assign stat.bad_range  = lo_r > hi_r;
  assign stat.is_init    = cmd_r == rlr_pkg::CMD_INIT;
  assign stat.count_zero = count_r == '0;
  assign stat.idx_last   = rlr_pkg::CNT_W'(idx_r) == (count_r - rlr_pkg::CNT_W'(1));
  assign stat.list_full  = count_r == rlr_pkg::CNT_W'(rlr_pkg::MAX_REGIONS);
  assign stat.out_free   = !out_tvalid_r || out_tready;

  always_comb begin
    wr_en   = cmd.init_wr || (cmd.proc && keep) || cmd.split_wr;
    wr_addr = {~bank_r, n_r[rlr_pkg::IDX_W-1:0]};
    wr_data = piece;
    if (cmd.init_wr) begin
      wr_addr = {bank_r, {rlr_pkg::IDX_W{1'b0}}};
      wr_data = '{low: lo_r, high: hi_r};
    end else if (cmd.split_wr) begin
      wr_data = '{low: hi_r, high: rd_q_r.high};
    end
  end

  assign rd_addr = {bank_r, idx_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_q_r <= mem_r[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r       <= 1'b0;
      count_r      <= '0;
      idx_r        <= '0;
      n_r          <= '0;
      copy_r       <= 1'b0;
      status_r     <= rlr_pkg::ST_OK;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + rlr_pkg::IDX_W'(1);
      end
      if (cmd.walk_clr) begin
        n_r    <= '0;
        copy_r <= 1'b0;
      end else begin
        if ((cmd.proc && keep) || cmd.split_wr) begin
          n_r <= n_r + rlr_pkg::CNT_W'(1);
        end
        if (cmd.proc && stat.split_hit) begin
          copy_r <= 1'b1;
        end
      end
      if (cmd.init_wr) begin
        count_r <= rlr_pkg::CNT_W'(1);
      end else if (cmd.commit) begin
        count_r <= n_r;
        bank_r  <= ~bank_r;
      end
      if (cmd.set_status) begin
        status_r <= cmd.status_val;
      end
      if (cmd.emit_ld || cmd.emit_empty) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_tuser;
      lo_r  <= in_tdata[rlr_pkg::ADDR_BITS-1:0];
      hi_r  <= in_tdata[2*rlr_pkg::ADDR_BITS-1:rlr_pkg::ADDR_BITS];
    end
    if (cmd.emit_ld) begin
      out_low_r         <= rd_q_r.low;
      out_high_r        <= rd_q_r.high;
      out_entry_valid_r <= 1'b1;
      out_count_r       <= count_r;
      out_status_r      <= status_r;
      out_last_r        <= stat.idx_last;
    end else if (cmd.emit_empty) begin
      out_low_r         <= '0;
      out_high_r        <= '0;
      out_entry_valid_r <= 1'b0;
      out_count_r       <= '0;
      out_status_r      <= status_r;
      out_last_r        <= 1'b1;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{rlr_pkg::OUT_PAD_W{1'b0}}, out_status_r, out_count_r,
                       out_high_r, out_low_r};
  assign out_tuser  = out_entry_valid_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// File: hdl/region_list_reserve.sv
// region list reserve: top level, free-region list with init and reserve commands
// depends on rlr_pkg, rlr_ctrl and rlr_dp
`default_nettype none

// channel  | ports          | word
// ---------+----------------+------------------------------------------------
// input    | in_t*          | one command: init list or reserve a range
// result   | out_t*         | one region (or an empty marker), run ends with tlast
//
// a reserve walks each entry of the live bank of the store through its single
// registered read port, writes the kept pieces and one extra piece per split
// into the scratch bank, then emits one word per listed region.
// reset clears the region count, bank select, walk state, status and output
// valid; store entries are written before read.
// the next command is taken once the last word of a run sits in the output
// register; a stalled sink holds the emit walk before each read.

module region_list_reserve (
  input  wire                               clk,
  input  wire                               rst_n,
  // command stream
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // range_low [47:0], range_high [95:48]
  input  wire  [rlr_pkg::IN_DATA_W-1:0]     in_tdata,
  // command [0]
  input  wire                               in_tuser,
  // region stream
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // entry_low [47:0], entry_high [95:48], entry_count [100:96], status [102:101]
  output logic [rlr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // entry_valid [0]
  output logic                              out_tuser,
  // last
  output logic                              out_tlast
);

  rlr_pkg::ctrl_cmd_t cmd;
  rlr_pkg::dp_stat_t  stat;

  // sequencer: walk, split, commit and emit steps
  rlr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store with a live bank and a scratch bank; a reserve builds the new list
  // in the scratch bank and swaps banks only when it finishes without overflow
  rlr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

`default_nettype wire
